### hw/rtl/allocator_free_block_list_defines.svh
// Assertion macros used by allocator_free_block_list.sv.
`ifndef ALLOCATOR_FREE_BLOCK_LIST_DEFINES_SVH
`define ALLOCATOR_FREE_BLOCK_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define AFBL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AFBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AFBL_ASSERT(lbl, clk, rst, prop, msg)
`define AFBL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/afbl_pkg.sv
`timescale 1ns / 1ps
package afbl_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ADDR_BITS   = 32;

   localparam int FIELD_W = 32;
   localparam int ADDR_W  = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
   localparam int SIZE_W  = 32;
   localparam int HDR_W   = 8;
   localparam int SUM_W   = SIZE_W + 2;
   localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [HDR_W-1:0] HDR_RESET = HDR_W'(16);

   typedef logic [TABLE_DEPTH-1:0] row_type;
   typedef logic [COUNT_W-1:0]     count_type;

   typedef enum logic [2:0] {
      MODE_INSERT    = 3'd0,
      MODE_REMOVE    = 3'd1,
      MODE_FIRST_FIT = 3'd2,
      MODE_CONTAINS  = 3'd3,
      MODE_PREV      = 3'd4,
      MODE_NEXT      = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_ABSENT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SH_HOLD,
      SH_FROM_PREV,
      SH_FROM_NEXT
   } shift_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PICK
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
   } entry_type;

   // query broadcast to every cell
   typedef struct packed {
      logic [2:0]        mode;
      logic [ADDR_W-1:0] addr;
      logic [SIZE_W-1:0] size;
      logic [SUM_W-1:0]  next_end;
      logic [HDR_W-1:0]  hdr;
   } query_type;

endpackage

### hw/rtl/afbl_cell.sv
`timescale 1ns / 1ps
module afbl_cell (
   input  logic                clock,
   input  logic                reset,
   input  afbl_pkg::query_type query,
   input  afbl_pkg::shift_type shift,
   input  afbl_pkg::entry_type prev_entry,
   input  afbl_pkg::entry_type next_entry,
   output afbl_pkg::entry_type entry,
   output logic                match
);

   logic                      valid_ff;
   logic                      valid_in;
   logic [afbl_pkg::ADDR_W-1:0] addr_ff;
   logic [afbl_pkg::ADDR_W-1:0] addr_in;
   logic [afbl_pkg::SIZE_W-1:0] size_ff;
   logic [afbl_pkg::SIZE_W-1:0] size_in;
   logic                      match_ff;
   logic                      match_in;
   logic [afbl_pkg::SUM_W-1:0]  own_end;

   assign entry = '{valid: valid_ff, addr: addr_ff, size: size_ff};
   assign match = match_ff;

   assign own_end = afbl_pkg::SUM_W'(addr_ff) + afbl_pkg::SUM_W'(query.hdr)
                  + afbl_pkg::SUM_W'(size_ff);

   always_comb begin
      match_in = 1'b0;
      case (query.mode)
         afbl_pkg::MODE_REMOVE, afbl_pkg::MODE_CONTAINS: begin
            match_in = (addr_ff == query.addr);
         end
         afbl_pkg::MODE_FIRST_FIT: begin
            match_in = (size_ff >= query.size);
         end
         afbl_pkg::MODE_PREV: begin
            match_in = (own_end == afbl_pkg::SUM_W'(query.addr));
         end
         afbl_pkg::MODE_NEXT: begin
            match_in = (query.next_end == afbl_pkg::SUM_W'(addr_ff));
         end
         default: begin
            match_in = 1'b0;
         end
      endcase
      match_in = match_in & valid_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      size_in  = size_ff;
      case (shift)
         afbl_pkg::SH_FROM_PREV: begin
            valid_in = prev_entry.valid;
            addr_in  = prev_entry.addr;
            size_in  = prev_entry.size;
         end
         afbl_pkg::SH_FROM_NEXT: begin
            valid_in = next_entry.valid;
            addr_in  = next_entry.addr;
            size_in  = next_entry.size;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      addr_ff  <= addr_in;
      size_ff  <= size_in;
      match_ff <= match_in;
   end

endmodule

### hw/rtl/allocator_free_block_list.sv
`timescale 1ns / 1ps
// channel   ports                              handshake
// request   req_mode/block_addr/block_size     beat taken when start & !busy
// response  rsp_found/match_addr/match_size,   one beat per request, rsp_strobe
//           rsp_entry_count, rsp_status        high one cycle, no back-pressure
// config    csr_wr_data                        written when csr_wr_en
//
// After the edge that takes a request, busy stays high through the EVAL state,
// in which all cells compare against the query, and the PICK state, for the
// priority pick and the shift of the cell row. The response is on the ports in
// the next cycle, and a new request can be taken at the edge that ends it; no
// request is taken while busy. Reset clears the table and sets the header size to 16;
// there is no clearing pass.
`include "allocator_free_block_list_defines.svh"
module allocator_free_block_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_block_addr,
   input  logic [31:0] req_block_size,
   output logic        rsp_strobe,
   output logic        rsp_found,
   output logic [31:0] rsp_match_addr,
   output logic [31:0] rsp_match_size,
   output logic [4:0]  rsp_entry_count,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   localparam int DEPTH = afbl_pkg::TABLE_DEPTH;

   afbl_pkg::state_type         state_ff;
   afbl_pkg::state_type         state_in;
   afbl_pkg::count_type         count_ff;
   afbl_pkg::count_type         count_in;
   logic [afbl_pkg::HDR_W-1:0]  hdr_ff;
   afbl_pkg::query_type         query_ff;
   afbl_pkg::query_type         query_in;

   logic                        rsp_strobe_ff;
   logic                        rsp_strobe_in;
   logic                        rsp_found_ff;
   logic                        rsp_found_in;
   logic [31:0]                 rsp_addr_ff;
   logic [31:0]                 rsp_addr_in;
   logic [31:0]                 rsp_size_ff;
   logic [31:0]                 rsp_size_in;
   logic [4:0]                  rsp_count_ff;
   logic [4:0]                  rsp_count_in;
   logic [1:0]                  rsp_status_ff;
   logic [1:0]                  rsp_status_in;

   afbl_pkg::entry_type         entries   [DEPTH];
   afbl_pkg::entry_type         prev_ents [DEPTH];
   afbl_pkg::entry_type         next_ents [DEPTH];
   afbl_pkg::shift_type         shifts    [DEPTH];
   afbl_pkg::row_type           match_row;
   afbl_pkg::row_type           valid_row;
   afbl_pkg::row_type           hit_row;
   afbl_pkg::row_type           tail_row;
   afbl_pkg::entry_type         hit_entry;
   afbl_pkg::entry_type         new_entry;
   logic                        accept;

   assign accept = start && (state_ff == afbl_pkg::ST_IDLE);
   assign busy   = (state_ff != afbl_pkg::ST_IDLE);

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_addr  = rsp_addr_ff;
   assign rsp_match_size  = rsp_size_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   assign new_entry = '{valid: 1'b1, addr: query_ff.addr, size: query_ff.size};

   // lowest set match wins; tail marks the hit cell and all behind it
   assign hit_row  = match_row & (~match_row + DEPTH'(1));
   assign tail_row = ~(hit_row - DEPTH'(1));

   always_comb begin
      hit_entry = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit_row[i]) begin
            hit_entry = hit_entry | entries[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         prev_ents[i] = (i == 0) ? new_entry : entries[(i == 0) ? 0 : i - 1];
         next_ents[i] = (i == DEPTH - 1) ? afbl_pkg::entry_type'('0)
                                         : entries[(i == DEPTH - 1) ? i : i + 1];
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         afbl_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .query      (query_ff),
            .shift      (shifts[g]),
            .prev_entry (prev_ents[g]),
            .next_entry (next_ents[g]),
            .entry      (entries[g]),
            .match      (match_row[g])
         );
         assign valid_row[g] = entries[g].valid;
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      query_in      = query_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_addr_in   = '0;
      rsp_size_in   = '0;
      rsp_count_in  = 5'(count_ff);
      rsp_status_in = afbl_pkg::STAT_OK;
      for (int i = 0; i < DEPTH; i++) begin
         shifts[i] = afbl_pkg::SH_HOLD;
      end
      unique case (state_ff)
         afbl_pkg::ST_IDLE: begin
            if (accept) begin
               query_in.mode     = req_mode;
               query_in.addr     = req_block_addr[afbl_pkg::ADDR_W-1:0];
               query_in.size     = req_block_size;
               query_in.next_end = afbl_pkg::SUM_W'(req_block_addr[afbl_pkg::ADDR_W-1:0])
                                 + afbl_pkg::SUM_W'(hdr_ff)
                                 + afbl_pkg::SUM_W'(req_block_size);
               query_in.hdr      = hdr_ff;
               state_in = afbl_pkg::ST_EVAL;
            end
         end
         afbl_pkg::ST_EVAL: begin
            state_in = afbl_pkg::ST_PICK;
         end
         afbl_pkg::ST_PICK: begin
            state_in      = afbl_pkg::ST_IDLE;
            rsp_strobe_in = 1'b1;
            case (query_ff.mode)
               afbl_pkg::MODE_INSERT: begin
                  if (count_ff == afbl_pkg::count_type'(DEPTH)) begin
                     rsp_status_in = afbl_pkg::STAT_FULL;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        shifts[i] = afbl_pkg::SH_FROM_PREV;
                     end
                     count_in = count_ff + afbl_pkg::count_type'(1);
                  end
               end
               afbl_pkg::MODE_REMOVE, afbl_pkg::MODE_FIRST_FIT, afbl_pkg::MODE_CONTAINS,
               afbl_pkg::MODE_PREV, afbl_pkg::MODE_NEXT: begin
                  if (|match_row) begin
                     rsp_found_in = 1'b1;
                     rsp_addr_in  = 32'(hit_entry.addr);
                     rsp_size_in  = hit_entry.size;
                     if (query_ff.mode == afbl_pkg::MODE_REMOVE) begin
                        for (int i = 0; i < DEPTH; i++) begin
                           if (tail_row[i]) begin
                              shifts[i] = afbl_pkg::SH_FROM_NEXT;
                           end
                        end
                        count_in = count_ff - afbl_pkg::count_type'(1);
                     end
                  end else if (query_ff.mode == afbl_pkg::MODE_REMOVE) begin
                     rsp_status_in = afbl_pkg::STAT_ABSENT;
                  end
               end
               default: begin
                  rsp_status_in = afbl_pkg::STAT_OK;
               end
            endcase
            rsp_count_in = 5'(count_in);
         end
         default: begin
            state_in = afbl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= afbl_pkg::ST_IDLE;
         count_ff      <= '0;
         hdr_ff        <= afbl_pkg::HDR_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            hdr_ff <= csr_wr_data;
         end
      end
      query_ff      <= query_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   `AFBL_ASSERT(a_beat_from_pick, clock, reset, rsp_strobe |-> $past(state_ff == afbl_pkg::ST_PICK), "response beat without a pick cycle")
   `AFBL_ASSERT(a_count_matches_valid, clock, reset, $countones(valid_row) == 32'(count_ff), "entry count and valid cells disagree")
   `AFBL_ASSERT(a_count_bound, clock, reset, count_ff <= afbl_pkg::count_type'(DEPTH), "entry count above table depth")
   `AFBL_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy, "accepted beat did not raise busy")
   `AFBL_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_strobe, "not idle after reset")

endmodule
